// ----- hw/rtl/alu8f_pkg.sv -----
// Package for the eight-bit ALU with flags: operation codes and transaction types.
// Used by eight_bit_alu_with_flags_top and its checker alu8f_chk; depends on nothing.
`default_nettype none

package alu8f_pkg;

  // Operation codes. Codes above MODE_LOAD are no-ops.
  typedef enum logic [3:0] {
    MODE_ADC  = 4'd0,
    MODE_SBC  = 4'd1,
    MODE_AND  = 4'd2,
    MODE_OR   = 4'd3,
    MODE_XOR  = 4'd4,
    MODE_ASL  = 4'd5,
    MODE_LSR  = 4'd6,
    MODE_ROL  = 4'd7,
    MODE_ROR  = 4'd8,
    MODE_CMP  = 4'd9,
    MODE_BIT  = 4'd10,
    MODE_INC  = 4'd11,
    MODE_DEC  = 4'd12,
    MODE_LOAD = 4'd13
  } mode_e;

  localparam int unsigned ByteW = 8;

  // One operation request.
  typedef struct packed {
    logic [3:0]       mode;
    logic [ByteW-1:0] reg_value;
    logic [ByteW-1:0] mem_value;
    logic             carry_in;
    logic             zero_in;
    logic             overflow_in;
    logic             negative_in;
  } alu_in_t;

  // One operation result.
  typedef struct packed {
    logic [ByteW-1:0] result;
    logic             writes_back;
    logic             carry_out;
    logic             zero_out;
    logic             overflow_out;
    logic             negative_out;
  } alu_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/eight_bit_alu_with_flags_top.sv -----
// Top level of the eight-bit ALU with N, V, Z, C flags (binary mode only).
// Depends on alu8f_pkg for the operation codes and the transaction structs.
`default_nettype none

//  Channel   Ports                     Handshake
//  --------  ------------------------  -------------------------------------------
//  request   start, busy, op_i         taken at a rising edge with start high and
//                                      busy low
//  result    done_o, res_o             valid for the single cycle done_o is high
//
// The block accepts one transaction every clock cycle; busy never rises.
// Each taken request is held in the input register, then passes through the
// single-pass ALU logic into the result register.
// Results leave in request order and the receiver cannot stall them.
// Reset (rst_ni low, asynchronous) clears both pipeline valid bits, so no
// result strobe is issued for a request that was in flight at reset.

module eight_bit_alu_with_flags_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  alu8f_pkg::alu_in_t  op_i,
  output logic                done_o,
  output alu8f_pkg::alu_out_t res_o
);

  // Input stage: the accepted request is captured here.
  logic               in_vld_q;
  alu8f_pkg::alu_in_t in_q;

  // Result stage.
  logic                res_vld_q;
  alu8f_pkg::alu_out_t res_q;
  alu8f_pkg::alu_out_t res_d;

  // The pipeline never stalls, so the request side is always open.
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start;
      res_vld_q <= in_vld_q;
    end
  end

  // Payload registers carry no reset; their valid bits qualify them.
  always_ff @(posedge clk_i) begin
    if (start) begin
      in_q <= op_i;
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  // Shared nine-bit adder serves add, subtract and compare. Subtract and
  // compare add the inverted memory byte; compare forces the carry in to one
  // so that the sum is reg - mem and the carry out means reg >= mem.
  logic [7:0] add_b;
  logic       add_cin;
  logic [8:0] add_sum;
  logic       add_ovf;
  logic       is_add;
  logic       is_cmp;

  always_comb begin
    is_add  = (in_q.mode == alu8f_pkg::MODE_ADC);
    is_cmp  = (in_q.mode == alu8f_pkg::MODE_CMP);
    add_b   = is_add ? in_q.mem_value : ~in_q.mem_value;
    add_cin = is_cmp ? 1'b1 : in_q.carry_in;
    add_sum = {1'b0, in_q.reg_value} + {1'b0, add_b} + {8'd0, add_cin};
    // Signed overflow: both operands differ in sign from the result.
    add_ovf = (in_q.reg_value[7] ^ add_sum[7]) & (add_b[7] ^ add_sum[7]);
  end

  // Single pass through the operation select and the flag logic.
  logic set_zn;

  always_comb begin
    res_d.result       = in_q.reg_value;
    res_d.writes_back  = 1'b1;
    res_d.carry_out    = in_q.carry_in;
    res_d.zero_out     = in_q.zero_in;
    res_d.overflow_out = in_q.overflow_in;
    res_d.negative_out = in_q.negative_in;
    set_zn             = 1'b1;

    case (in_q.mode)
      alu8f_pkg::MODE_ADC,
      alu8f_pkg::MODE_SBC: begin
        res_d.result       = add_sum[7:0];
        res_d.carry_out    = add_sum[8];
        res_d.overflow_out = add_ovf;
      end
      alu8f_pkg::MODE_AND: begin
        res_d.result = in_q.reg_value & in_q.mem_value;
      end
      alu8f_pkg::MODE_OR: begin
        res_d.result = in_q.reg_value | in_q.mem_value;
      end
      alu8f_pkg::MODE_XOR: begin
        res_d.result = in_q.reg_value ^ in_q.mem_value;
      end
      alu8f_pkg::MODE_ASL: begin
        res_d.result    = {in_q.reg_value[6:0], 1'b0};
        res_d.carry_out = in_q.reg_value[7];
      end
      alu8f_pkg::MODE_LSR: begin
        res_d.result    = {1'b0, in_q.reg_value[7:1]};
        res_d.carry_out = in_q.reg_value[0];
      end
      alu8f_pkg::MODE_ROL: begin
        res_d.result    = {in_q.reg_value[6:0], in_q.carry_in};
        res_d.carry_out = in_q.reg_value[7];
      end
      alu8f_pkg::MODE_ROR: begin
        res_d.result    = {in_q.carry_in, in_q.reg_value[7:1]};
        res_d.carry_out = in_q.reg_value[0];
      end
      alu8f_pkg::MODE_CMP: begin
        res_d.result      = add_sum[7:0];
        res_d.carry_out   = add_sum[8];
        res_d.writes_back = 1'b0;
      end
      alu8f_pkg::MODE_BIT: begin
        // N and V come straight from the memory byte, Z from the AND.
        res_d.result       = in_q.reg_value & in_q.mem_value;
        res_d.writes_back  = 1'b0;
        res_d.negative_out = in_q.mem_value[7];
        res_d.overflow_out = in_q.mem_value[6];
        res_d.zero_out     = ((in_q.reg_value & in_q.mem_value) == 8'd0);
        set_zn             = 1'b0;
      end
      alu8f_pkg::MODE_INC: begin
        res_d.result = in_q.reg_value + 8'd1;
      end
      alu8f_pkg::MODE_DEC: begin
        res_d.result = in_q.reg_value - 8'd1;
      end
      alu8f_pkg::MODE_LOAD: begin
        res_d.result = in_q.mem_value;
      end
      default: begin
        // Unused codes do nothing: no write-back, every flag passes through.
        res_d.writes_back = 1'b0;
        set_zn            = 1'b0;
      end
    endcase

    if (set_zn) begin
      res_d.zero_out     = (res_d.result == 8'd0);
      res_d.negative_out = res_d.result[7];
    end
  end

  assign done_o = res_vld_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/alu8f_chk.sv -----
// Port-level checker for eight_bit_alu_with_flags_top, attached by a bind.
// Depends on alu8f_pkg for the operation codes and the transaction structs.
`default_nettype none

module alu8f_chk (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 start,
  input wire                 busy,
  input alu8f_pkg::alu_in_t  op_i,
  input wire                 done_o,
  input alu8f_pkg::alu_out_t res_o
);

  // Every accepted transaction produces its result strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("accepted transaction produced no result");

  // No result strobe without a matching accepted transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result strobe without an accepted transaction");

  // The block never holds requests off.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // Only compare, bit test and unused codes suppress write-back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.writes_back) |->
      ($past(op_i.mode, 2) == alu8f_pkg::MODE_CMP ||
       $past(op_i.mode, 2) == alu8f_pkg::MODE_BIT ||
       $past(op_i.mode, 2) > alu8f_pkg::MODE_LOAD))
    else $error("write-back suppressed for a writing operation");

  // A written-back result always sets Z and N from itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.writes_back) |->
      (res_o.zero_out == (res_o.result == 8'd0) &&
       res_o.negative_out == res_o.result[7]))
    else $error("Z or N disagrees with the written result");

endmodule

bind eight_bit_alu_with_flags_top alu8f_chk u_alu8f_chk (.*);

`default_nettype wire
